@@ rtl/tcp_pkg.sv @@
`default_nettype none

package tcp_pkg;

    localparam int MAX_FRAME = 64;
    localparam int FRAC_BITS = 16;
    localparam int INT_BITS  = 31 - FRAC_BITS;
    localparam int POS_W     = 7;

    localparam logic [FRAC_BITS-1:0] WEIGHT_TENTH =
        FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [FRAC_BITS-1:0] FRAC_HALF = FRAC_BITS'(64'd1 << (FRAC_BITS - 1));
    localparam logic [FRAC_BITS-1:0] FRAC_MAX  = '1;
    localparam logic [INT_BITS-1:0]  INT_MAX   = '1;
    localparam logic [3:0]           DEC_BASE  = 4'd10;

    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_K      = 8'h4B;
    localparam logic [7:0] CH_D      = 8'h44;

    localparam logic [7:0] LOOP_CHAR_RESET = 8'h31;

    localparam logic [1:0] GAIN_PROP  = 2'd0;
    localparam logic [1:0] GAIN_INTEG = 2'd1;
    localparam logic [1:0] GAIN_DERIV = 2'd2;

    typedef struct packed {
        logic restart;
        logic feed;
    } val_ctrl_t;

    typedef struct packed {
        logic                 negative;
        logic                 bad;
        logic [INT_BITS-1:0]  int_part;
        logic [FRAC_BITS-1:0] frac;
    } val_stat_t;

endpackage

`default_nettype wire

@@ rtl/tuning_command_parser.sv @@
// Parses gain-tuning frames such as "P1=0.5!" from a byte stream, one byte per
// item. The first byte picks the gain (P, K, D), the second must match the
// loop_char register, and the decimal after the last '=' becomes signed Q16.16
// with a saturated integer part. On '!' a matching frame yields one gain write;
// a malformed value, or a frame hitting 64 bytes without '!', yields zero with
// m_well_formed low. Each byte passes through an input register, combinational
// parsing and a result register, so one item is taken per cycle unless m_ready
// stalls the result; m_valid is registered alongside the result.
`default_nettype none

module tuning_command_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        loop_char_we,
    input  wire logic [7:0]  loop_char_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_which_gain,
    output logic [31:0]      m_gain_value,
    output logic             m_well_formed
);
    import tcp_pkg::*;

    logic             in_vld_reg;
    logic [7:0]       in_byte_reg;
    logic [7:0]       loop_char_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       key_reg, key_next;
    logic [7:0]       second_reg, second_next;
    logic             seen_eq_reg, seen_eq_next;
    logic             m_valid_reg;
    logic [1:0]       gain_reg;
    logic [31:0]      value_reg;
    logic             ok_reg;

    logic             out_free, fire, is_bang, is_eq, limit_hit, frame_end;
    logic             key_ok, emit, ok_now;
    logic [1:0]       key_gain;
    logic [POS_W-1:0] pos_inc;
    logic [31:0]      mag, value_now;
    val_ctrl_t        vctrl;
    val_stat_t        vstat;

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = in_vld_reg && out_free;
    assign s_ready  = aresetn && (!in_vld_reg || out_free);

    assign is_bang   = (in_byte_reg == CH_BANG);
    assign is_eq     = (in_byte_reg == CH_EQUALS);
    assign pos_inc   = pos_reg + POS_W'(1);
    assign limit_hit = !is_bang && (pos_inc >= POS_W'(MAX_FRAME));
    assign frame_end = is_bang || limit_hit;

    always_comb begin
        key_ok   = 1'b1;
        key_gain = GAIN_PROP;
        unique case (key_reg)
            CH_P:    key_gain = GAIN_PROP;
            CH_K:    key_gain = GAIN_INTEG;
            CH_D:    key_gain = GAIN_DERIV;
            default: key_ok = 1'b0;
        endcase
        if (pos_reg < POS_W'(2) || second_reg != loop_char_reg) begin
            key_ok = 1'b0;
        end
    end

    assign vctrl.restart = fire && (frame_end || is_eq);
    assign vctrl.feed    = fire && seen_eq_reg && !frame_end && !is_eq;

    tcp_value_parse u_value (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rx_byte (in_byte_reg),
        .ctrl    (vctrl),
        .stat    (vstat)
    );

    // limit_hit implies pos >= 2, so registered key fields are already final
    assign emit      = key_ok && frame_end;
    assign ok_now    = is_bang && seen_eq_reg && !vstat.bad;
    assign mag       = {1'b0, vstat.int_part, vstat.frac};
    assign value_now = !ok_now ? 32'd0 : (vstat.negative ? (32'd0 - mag) : mag);

    always_comb begin
        pos_next     = pos_reg;
        key_next     = key_reg;
        second_next  = second_reg;
        seen_eq_next = seen_eq_reg;
        if (fire) begin
            if (frame_end) begin
                pos_next     = '0;
                key_next     = '0;
                second_next  = '0;
                seen_eq_next = 1'b0;
            end else begin
                pos_next = pos_inc;
                if (pos_reg == POS_W'(0)) begin
                    key_next = in_byte_reg;
                end
                if (pos_reg == POS_W'(1)) begin
                    second_next = in_byte_reg;
                end
                if (is_eq) begin
                    seen_eq_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg    <= 1'b0;
            loop_char_reg <= LOOP_CHAR_RESET;
            pos_reg       <= '0;
            key_reg       <= '0;
            second_reg    <= '0;
            seen_eq_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (loop_char_we) begin
                loop_char_reg <= loop_char_wdata;
            end
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (fire) begin
                in_vld_reg <= 1'b0;
            end
            pos_reg     <= pos_next;
            key_reg     <= key_next;
            second_reg  <= second_next;
            seen_eq_reg <= seen_eq_next;
            if (out_free) begin
                m_valid_reg <= fire && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (fire && emit) begin
            gain_reg  <= key_gain;
            value_reg <= value_now;
            ok_reg    <= ok_now;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_which_gain  = gain_reg;
    assign m_gain_value  = value_reg;
    assign m_well_formed = ok_reg;

    a_malformed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_well_formed) |-> (m_gain_value == 32'd0))
        else $error("malformed result carries nonzero gain");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < POS_W'(MAX_FRAME))
        else $error("frame position past limit");

    a_bang_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_bang) |=> (pos_reg == '0 && !seen_eq_reg))
        else $error("terminator did not restart frame");

    a_gain_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && emit) |=> (gain_reg != 2'd3))
        else $error("result names no gain");

endmodule

`default_nettype wire

@@ rtl/tcp_value_parse.sv @@
`default_nettype none

module tcp_value_parse (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        rx_byte,
    input  wire tcp_pkg::val_ctrl_t ctrl,
    output tcp_pkg::val_stat_t     stat
);
    import tcp_pkg::*;

    logic                 started_reg, started_next;
    logic                 neg_reg, neg_next;
    logic                 frac_mode_reg, frac_mode_next;
    logic                 bad_reg, bad_next;
    logic [INT_BITS-1:0]  int_reg, int_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [FRAC_BITS-1:0] weight_reg, weight_next;

    logic                   is_digit;
    logic [3:0]             digit;
    logic [FRAC_BITS+4:0]   frac_add;
    logic [2*FRAC_BITS:0]   weight_prod;
    logic [INT_BITS+4:0]    int_mac;

    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign digit    = rx_byte[3:0];

    assign frac_add = (FRAC_BITS+5)'(frac_reg)
                    + (FRAC_BITS+5)'(digit) * (FRAC_BITS+5)'(weight_reg);
    assign weight_prod = (2*FRAC_BITS+1)'(weight_reg) * (2*FRAC_BITS+1)'(WEIGHT_TENTH)
                       + (2*FRAC_BITS+1)'(FRAC_HALF);
    assign int_mac = (INT_BITS+5)'(int_reg) * (INT_BITS+5)'(DEC_BASE)
                   + (INT_BITS+5)'(digit);

    always_comb begin
        started_next   = started_reg;
        neg_next       = neg_reg;
        frac_mode_next = frac_mode_reg;
        bad_next       = bad_reg;
        int_next       = int_reg;
        frac_next      = frac_reg;
        weight_next    = weight_reg;
        if (ctrl.restart) begin
            started_next   = 1'b0;
            neg_next       = 1'b0;
            frac_mode_next = 1'b0;
            bad_next       = 1'b0;
            int_next       = '0;
            frac_next      = '0;
            weight_next    = WEIGHT_TENTH;
        end else if (ctrl.feed) begin
            started_next = 1'b1;
            priority if (!started_reg && rx_byte == CH_MINUS) begin
                neg_next = 1'b1;
            end else if (rx_byte == CH_POINT) begin
                if (frac_mode_reg) begin
                    bad_next = 1'b1;
                end else begin
                    frac_mode_next = 1'b1;
                end
            end else if (is_digit) begin
                if (frac_mode_reg) begin
                    frac_next   = (frac_add > (FRAC_BITS+5)'(FRAC_MAX)) ?
                                  FRAC_MAX : frac_add[FRAC_BITS-1:0];
                    weight_next = weight_prod[FRAC_BITS +: FRAC_BITS];
                end else begin
                    int_next = (int_mac > (INT_BITS+5)'(INT_MAX)) ?
                               INT_MAX : int_mac[INT_BITS-1:0];
                end
            end else begin
                bad_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg   <= 1'b0;
            neg_reg       <= 1'b0;
            frac_mode_reg <= 1'b0;
            bad_reg       <= 1'b0;
            int_reg       <= '0;
            frac_reg      <= '0;
            weight_reg    <= WEIGHT_TENTH;
        end else begin
            started_reg   <= started_next;
            neg_reg       <= neg_next;
            frac_mode_reg <= frac_mode_next;
            bad_reg       <= bad_next;
            int_reg       <= int_next;
            frac_reg      <= frac_next;
            weight_reg    <= weight_next;
        end
    end

    assign stat.negative = neg_reg;
    assign stat.bad      = bad_reg;
    assign stat.int_part = int_reg;
    assign stat.frac     = frac_reg;

endmodule

`default_nettype wire
